// File: hw/rtl/sampson_inlier_counter_defines.svh
// ----------------------------------------------------------------------------
// Sampson inlier counter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPSON_INLIER_COUNTER_DEFINES_SVH
`define SAMPSON_INLIER_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter package
// Widths, register map, controller types and matrix entry selection.
// ----------------------------------------------------------------------------
package sic_pkg;

  // Saturation limit of the inlier count and the count width it needs.
  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);

  // Field widths.
  localparam int unsigned CoordW = 16;  // Q3.12 point coordinate
  localparam int unsigned EntryW = 16;  // Q1.14 matrix entry
  localparam int unsigned RowW   = 3 * EntryW;
  localparam int unsigned ThrW   = 16;  // Q0.16 threshold
  localparam int unsigned TotalW = 13;

  // Datapath widths.
  localparam int unsigned ProdW = EntryW + CoordW;   // entry times coordinate
  localparam int unsigned LinW  = 34;                // a and b, units 2^-26
  localparam int unsigned NumW  = 50;                // numerator, units 2^-38
  localparam int unsigned RndW  = 23;                // rounded a and b, units 2^-14
  localparam int unsigned SqW   = 2 * RndW;
  localparam int unsigned DenW  = 47;                // denominator, units 2^-28
  localparam int unsigned LhsW  = 56;                // |num| scaled to 2^-44
  localparam int unsigned RhsW  = ThrW + DenW;       // t * den, units 2^-44

  // The homogeneous coordinate 1.0 in Q3.12 and the rounding step to 2^-14.
  localparam int unsigned OneShift   = 12;
  localparam logic signed [CoordW-1:0] OneQ12 = CoordW'(1 << OneShift);
  localparam int unsigned RoundShift = 12;
  localparam int unsigned RoundHalf  = 1 << (RoundShift - 1);
  localparam int unsigned LhsShift   = 6;

  // Configuration port.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 64;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(66);

  typedef logic [1:0] sic_reg_idx_t;
  localparam sic_reg_idx_t RegRow0 = 2'd0;
  localparam sic_reg_idx_t RegRow1 = 2'd1;
  localparam sic_reg_idx_t RegRow2 = 2'd2;
  localparam sic_reg_idx_t RegThr  = 2'd3;

  // Row or column index of the 3x3 matrix.
  typedef logic [1:0] sic_idx_t;
  localparam sic_idx_t Idx0 = 2'd0;
  localparam sic_idx_t Idx1 = 2'd1;
  localparam sic_idx_t Idx2 = 2'd2;

  typedef struct packed {
    logic [RowW-1:0] row0;
    logic [RowW-1:0] row1;
    logic [RowW-1:0] row2;
    logic [ThrW-1:0] thr;
  } sic_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN0,
    ST_LIN1,
    ST_LIN2,
    ST_ACC2,
    ST_SCALE,
    ST_TEST
  } sic_state_e;

  typedef struct packed {
    logic     load;
    logic     lin_en;
    sic_idx_t lin_idx;
    logic     acc_en;
    sic_idx_t acc_idx;
    logic     scale_en;
    logic     test_en;
  } sic_cmd_t;

  typedef struct packed {
    logic set_end;
  } sic_sts_t;

  // Entry (r, c) of the matrix as a signed Q1.14 value.
  function automatic logic signed [EntryW-1:0] mat_entry(input sic_cfg_t cfg,
                                                         input sic_idx_t r,
                                                         input sic_idx_t c);
    logic [RowW-1:0] row;
    logic [EntryW-1:0] val;
    case (r)
      Idx0:    row = cfg.row0;
      Idx1:    row = cfg.row1;
      default: row = cfg.row2;
    endcase
    case (c)
      Idx0:    val = row[EntryW-1:0];
      Idx1:    val = row[2*EntryW-1:EntryW];
      default: val = row[3*EntryW-1:2*EntryW];
    endcase
    return $signed(val);
  endfunction

endpackage

// File: hw/rtl/sic_ifs.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter channels
// Valid/ready channels for correspondences in and inlier totals out.
// ----------------------------------------------------------------------------
interface sic_in_if;
  import sic_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] first_x;
  logic signed [CoordW-1:0] first_y;
  logic signed [CoordW-1:0] second_x;
  logic signed [CoordW-1:0] second_y;
  logic                     set_end;

  modport source (output valid, first_x, first_y, second_x, second_y, set_end,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, set_end,
                output ready);
endinterface

interface sic_out_if;
  import sic_pkg::*;

  logic              valid;
  logic              ready;
  logic [TotalW-1:0] inlier_total;

  modport source (output valid, inlier_total, input ready);
  modport sink (input valid, inlier_total, output ready);
endinterface

// File: hw/rtl/sampson_inlier_counter.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter
// Counts correspondences that fit a candidate essential matrix.
// ----------------------------------------------------------------------------
// Usage: correspondences arrive on corr_i, a valid/ready channel carrying two
// Q3.12 points and a set_end flag. A transfer happens at a rising edge with
// valid and ready both high. For each correspondence the block forms the
// Sampson numerator and denominator and counts it as an inlier when the
// denominator is nonzero and |num| < t*den. The count saturates at the
// package limit. On a correspondence marked set_end the count, including that
// item, is posted on res_o and cleared for the next set.
// Steps: accept, three linear passes, a final accumulation, scale and test.
// The linear stage builds one element of E*x2 and E^T*x1 per cycle with four
// shared multipliers over three passes; each element is accumulated in the
// cycle after it is built; scale registers the threshold multiply and test
// makes the compare. corr_i is ready only between correspondences. A set's
// total appears on res_o the cycle after the closing item's test.
// Stalls: res_o holds its total until taken. The next set's items are still
// accepted meanwhile; only a second closing item waits in its test step.
// Reset clears the count, drops res_o valid, zeroes the matrix rows and sets
// the threshold to 66. Registers sit on the APB port at byte addresses 0, 8,
// 16 and 24; the user must write them only while the block is idle, unguarded.
// ----------------------------------------------------------------------------
module sampson_inlier_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sic_pkg::AddrW-1:0] paddr,
  input  logic [sic_pkg::DataW-1:0] pwdata,
  output logic [sic_pkg::DataW-1:0] prdata,
  output logic                      pready,
  sic_in_if.sink                    corr_i,
  sic_out_if.source                 res_o
);
  import sic_pkg::*;

  sic_cfg_t cfg;
  sic_cmd_t cmd;
  sic_sts_t sts;

  sic_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_i.valid),
    .in_ready_o  (corr_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sic_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg),
    .first_x_i      (corr_i.first_x),
    .first_y_i      (corr_i.first_y),
    .second_x_i     (corr_i.second_x),
    .second_y_i     (corr_i.second_y),
    .set_end_i      (corr_i.set_end),
    .inlier_total_o (res_o.inlier_total)
  );

endmodule

// File: hw/rtl/sic_regs.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter registers
// APB register file holding the three matrix rows and the threshold.
// ----------------------------------------------------------------------------
module sic_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sic_pkg::AddrW-1:0] paddr,
  input  logic [sic_pkg::DataW-1:0] pwdata,
  output logic [sic_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output sic_pkg::sic_cfg_t         cfg_o
);
  import sic_pkg::*;

  sic_cfg_t     cfg_q;
  sic_reg_idx_t reg_idx;
  logic         wr_en;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[AddrW-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row0 <= '0;
      cfg_q.row1 <= '0;
      cfg_q.row2 <= '0;
      cfg_q.thr  <= ThrReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegRow0: cfg_q.row0 <= pwdata[RowW-1:0];
        RegRow1: cfg_q.row1 <= pwdata[RowW-1:0];
        RegRow2: cfg_q.row2 <= pwdata[RowW-1:0];
        RegThr:  cfg_q.thr  <= pwdata[ThrW-1:0];
        default: cfg_q.thr  <= cfg_q.thr;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegRow0: prdata = DataW'(cfg_q.row0);
      RegRow1: prdata = DataW'(cfg_q.row1);
      RegRow2: prdata = DataW'(cfg_q.row2);
      RegThr:  prdata = DataW'(cfg_q.thr);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sic_ctrl.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter controller
// Sequences one correspondence through the datapath and owns result valid.
// ----------------------------------------------------------------------------
`include "sampson_inlier_counter_defines.svh"

module sic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sic_pkg::sic_cmd_t cmd_o,
  input  sic_pkg::sic_sts_t sts_i
);
  import sic_pkg::*;

  sic_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LIN0;
        end
      end
      ST_LIN0: begin
        cmd_o.lin_en  = 1'b1;
        cmd_o.lin_idx = Idx0;
        state_d       = ST_LIN1;
      end
      ST_LIN1: begin
        cmd_o.lin_en  = 1'b1;
        cmd_o.lin_idx = Idx1;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_idx = Idx0;
        state_d       = ST_LIN2;
      end
      ST_LIN2: begin
        cmd_o.lin_en  = 1'b1;
        cmd_o.lin_idx = Idx2;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_idx = Idx1;
        state_d       = ST_ACC2;
      end
      ST_ACC2: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_idx = Idx2;
        state_d       = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_TEST;
      end
      ST_TEST: begin
        // A closing item waits here until the previous total is taken.
        if (!sts_i.set_end || !out_valid_q || out_ready_i) begin
          cmd_o.test_en = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.test_en && sts_i.set_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `SIC_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_LIN0, "accept did not start the pass")
  `SIC_ASSERT_NOW(a_no_overwrite, cmd_o.test_en && sts_i.set_end, !out_valid_q || out_ready_i, "pending total overwritten")
  `SIC_ASSERT_NEXT(a_total_posted, cmd_o.test_en && sts_i.set_end, out_valid_q, "closing item posted no total")
  `SIC_ASSERT_NEXT(a_scale_to_test, state_q == ST_SCALE, state_q == ST_TEST, "scale step not followed by test")

endmodule

// File: hw/rtl/sic_datapath.sv
// ----------------------------------------------------------------------------
// Sampson inlier counter datapath
// Linear terms, numerator and denominator accumulation, threshold test.
// ----------------------------------------------------------------------------
module sic_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sic_pkg::sic_cmd_t                 cmd_i,
  output sic_pkg::sic_sts_t                 sts_o,
  input  sic_pkg::sic_cfg_t                 cfg_i,
  input  logic signed [sic_pkg::CoordW-1:0] first_x_i,
  input  logic signed [sic_pkg::CoordW-1:0] first_y_i,
  input  logic signed [sic_pkg::CoordW-1:0] second_x_i,
  input  logic signed [sic_pkg::CoordW-1:0] second_y_i,
  input  logic                              set_end_i,
  output logic [sic_pkg::TotalW-1:0]        inlier_total_o
);
  import sic_pkg::*;

  // Latched correspondence.
  logic signed [CoordW-1:0] p1x_q, p1y_q, p2x_q, p2y_q;
  logic                     set_end_q;

  // Linear stage: one element of a = E*x2 and b = E^T*x1 per step.
  logic signed [EntryW-1:0] ea0, ea1, ea2, eb0, eb1, eb2;
  logic signed [ProdW-1:0]  pa0, pa1, pb0, pb1;
  logic signed [LinW-1:0]   a_d, b_d, a_q, b_q;

  // Accumulation stage.
  logic signed [CoordW-1:0] p1_sel;
  logic signed [NumW-1:0]   nterm, num_q;
  logic signed [LinW:0]     ra_sum, rb_sum, ra_shr, rb_shr;
  logic signed [RndW-1:0]   ra, rb;
  logic signed [SqW-1:0]    sq_a, sq_b;
  logic [DenW-1:0]          sq_sum, den_q;

  // Scale and test stages.
  logic [NumW-1:0]          mag;
  logic [LhsW-1:0]          lhs_q;
  logic [RhsW-1:0]          rhs_q;
  logic                     den_nz_q;
  logic                     inlier, count_inc;
  logic [CountW-1:0]        count_q, count_nx;
  logic [TotalW-1:0]        total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p1x_q     <= first_x_i;
      p1y_q     <= first_y_i;
      p2x_q     <= second_x_i;
      p2y_q     <= second_y_i;
      set_end_q <= set_end_i;
    end
  end

  assign sts_o.set_end = set_end_q;

  // Row lin_idx of E for a, column lin_idx of E for b. The third coordinate
  // is 1.0, so its term is a shift of the entry.
  assign ea0 = mat_entry(cfg_i, cmd_i.lin_idx, Idx0);
  assign ea1 = mat_entry(cfg_i, cmd_i.lin_idx, Idx1);
  assign ea2 = mat_entry(cfg_i, cmd_i.lin_idx, Idx2);
  assign eb0 = mat_entry(cfg_i, Idx0, cmd_i.lin_idx);
  assign eb1 = mat_entry(cfg_i, Idx1, cmd_i.lin_idx);
  assign eb2 = mat_entry(cfg_i, Idx2, cmd_i.lin_idx);

  assign pa0 = ProdW'(ea0) * ProdW'(p2x_q);
  assign pa1 = ProdW'(ea1) * ProdW'(p2y_q);
  assign pb0 = ProdW'(eb0) * ProdW'(p1x_q);
  assign pb1 = ProdW'(eb1) * ProdW'(p1y_q);

  assign a_d = LinW'(pa0) + LinW'(pa1) + (LinW'(ea2) <<< OneShift);
  assign b_d = LinW'(pb0) + LinW'(pb1) + (LinW'(eb2) <<< OneShift);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // Numerator term x1[i] * a[i].
  always_comb begin
    case (cmd_i.acc_idx)
      Idx0:    p1_sel = p1x_q;
      Idx1:    p1_sel = p1y_q;
      default: p1_sel = OneQ12;
    endcase
  end

  assign nterm = NumW'(p1_sel) * NumW'(a_q);

  // Round a[i] and b[i] to 2^-14, nearest with ties upward, then square.
  assign ra_sum = (LinW+1)'(a_q) + (LinW+1)'(RoundHalf);
  assign rb_sum = (LinW+1)'(b_q) + (LinW+1)'(RoundHalf);
  assign ra_shr = ra_sum >>> RoundShift;
  assign rb_shr = rb_sum >>> RoundShift;
  assign ra     = ra_shr[RndW-1:0];
  assign rb     = rb_shr[RndW-1:0];
  assign sq_a   = SqW'(ra) * SqW'(ra);
  assign sq_b   = SqW'(rb) * SqW'(rb);
  assign sq_sum = DenW'($unsigned(sq_a)) + DenW'($unsigned(sq_b));

  // Only the first two elements enter the denominator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      case (cmd_i.acc_idx)
        Idx0: begin
          num_q <= nterm;
          den_q <= sq_sum;
        end
        Idx1: begin
          num_q <= num_q + nterm;
          den_q <= den_q + sq_sum;
        end
        default: begin
          num_q <= num_q + nterm;
        end
      endcase
    end
  end

  // Bring both sides of |num| < t*den to units of 2^-44.
  assign mag = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      lhs_q    <= LhsW'(mag) << LhsShift;
      rhs_q    <= RhsW'(cfg_i.thr) * RhsW'(den_q);
      den_nz_q <= |den_q;
    end
  end

  assign inlier    = den_nz_q && (RhsW'(lhs_q) < rhs_q);
  assign count_inc = inlier && (count_q < CountW'(MaxPoints));
  assign count_nx  = count_q + CountW'(count_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.test_en) begin
      count_q <= set_end_q ? '0 : count_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.test_en && set_end_q) begin
      total_q <= TotalW'(count_nx);
    end
  end

  assign inlier_total_o = total_q;

endmodule
